FILE: sv/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg: shared types and constants for the life grid stepper
// Grid size, field widths, request/result structs, mode and register codes,
// and the sequencer state type.
// ----------------------------------------------------------------------------
package lag_pkg;

    // Grid storage size
    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;

    // Fixed field widths
    localparam int CFG_W     = 7;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 6;
    localparam int GEN_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Derived widths
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int COLS_CW   = $clog2(MAX_COLS + 1);
    localparam int ROWS_CW   = $clog2(MAX_ROWS + 1);
    localparam int AREA_W0   = (COLS_CW > ROWS_CW) ? COLS_CW : ROWS_CW;
    localparam int AREA_W    = (AREA_W0 > CFG_W) ? AREA_W0 : CFG_W;

    // Request modes
    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_READ     = 2'd1;
    localparam logic [1:0] MODE_ADVANCE  = 2'd2;
    localparam logic [1:0] MODE_READ_ALT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    typedef logic [MAX_COLS-1:0] t_row;

    typedef struct packed {
        logic [1:0]       mode;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             alive_in;
    } t_lag_in;

    typedef struct packed {
        logic             alive_out;
        logic [GEN_W-1:0] generation_count;
    } t_lag_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL_DONE,
        S_ADV_LOAD1,
        S_ADV_ROW,
        S_ADV_END
    } t_lag_state;

endpackage

FILE: sv/lag_row_unit.sv
// ----------------------------------------------------------------------------
// lag_row_unit: next-generation row from a three-row window
// Applies B3/S23 to every column of one row; columns past the active width
// and the row itself, when outside the active height, come out dead.
// ----------------------------------------------------------------------------
module lag_row_unit (
    input  lag_pkg::t_row              i_above,
    input  lag_pkg::t_row              i_cur,
    input  lag_pkg::t_row              i_below,
    input  logic [lag_pkg::AREA_W-1:0] i_width,
    input  logic                       i_row_en,
    output lag_pkg::t_row              o_next
);
    import lag_pkg::*;

    t_row                col_mask;
    logic [MAX_COLS+1:0] ext_above;
    logic [MAX_COLS+1:0] ext_cur;
    logic [MAX_COLS+1:0] ext_below;
    t_row                next_raw;

    // Active column mask
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (AREA_W'(c) < i_width);
        end
    end

    // Pad with a dead column on each side, hidden columns count as dead
    assign ext_above = {1'b0, i_above & col_mask, 1'b0};
    assign ext_cur   = {1'b0, i_cur   & col_mask, 1'b0};
    assign ext_below = {1'b0, i_below & col_mask, 1'b0};

    // Per-column neighbor count and rule
    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < MAX_COLS; c++) begin
            n = 4'(ext_above[c]) + 4'(ext_above[c+1]) + 4'(ext_above[c+2])
              + 4'(ext_cur[c])                        + 4'(ext_cur[c+2])
              + 4'(ext_below[c]) + 4'(ext_below[c+1]) + 4'(ext_below[c+2]);
            next_raw[c] = (n == 4'd3) || ((n == 4'd2) && ext_cur[c+1]);
        end
    end

    assign o_next = i_row_en ? (next_raw & col_mask) : '0;

endmodule

FILE: sv/life_automaton_grid_step.sv
// Cell write/read: accepted in idle with a registered row read; the done state
//   loads the result once the output register is free, then returns to idle.
// Generation advance: a load state primes the row window, then the single row-update
//   unit walks all MAX_ROWS rows, one per cycle, over the row memory (one read and
//   one write port); an end state then waits for a free output register.
// Reset (synchronous, active low): grid reads as all dead through per-row valid
//   bits, generation count zero, width and height 64. No clearing pass.
// ----------------------------------------------------------------------------
// life_automaton_grid_step: bounded-grid B3/S23 life automaton
// Row-wide memory of cells, a row-update unit reused for every row of a
// generation under a small sequencer, and single-cell write/read access.
// A finished result waits in the output register while the next request starts.
// ----------------------------------------------------------------------------
module life_automaton_grid_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lag_pkg::t_lag_in              i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lag_pkg::t_lag_out             o_out_req,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lag_pkg::CFG_W-1:0]     i_cfg_data
);
    import lag_pkg::*;

    // State and registers
    t_lag_state           r_state, n_state;
    t_lag_in              r_req;
    logic [CFG_W-1:0]     r_width, r_height;
    logic [GEN_W-1:0]     r_gen;
    logic                 r_out_valid;
    t_lag_out             r_out;
    t_row                 r_prev, r_cur;
    logic [ROW_IDX_W-1:0] r_row;
    t_row                 r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]  r_row_vld;
    t_row                 r_rd_q;
    logic                 r_rd_vld;

    // Control from the output decode
    logic                 in_accept;
    logic [ROW_IDX_W-1:0] mem_rd_addr;
    logic                 mem_wr_en;
    logic [ROW_IDX_W-1:0] mem_wr_addr;
    t_row                 mem_wr_data;
    logic                 out_load;
    t_lag_out             out_next;
    logic                 gen_inc;
    logic                 win_load;
    logic                 win_shift;

    // Datapath signals
    logic                 out_free;
    logic [AREA_W-1:0]    w_cfg, h_cfg, w_eff, h_eff;
    logic                 cell_in_area;
    t_row                 rd_row;
    t_row                 below_row;
    t_row                 new_row;
    logic                 row_en;
    logic                 last_row;

    // Active area, clipped to the stored grid
    assign w_cfg = AREA_W'(r_width);
    assign h_cfg = AREA_W'(r_height);
    assign w_eff = (w_cfg > AREA_W'(MAX_COLS)) ? AREA_W'(MAX_COLS) : w_cfg;
    assign h_eff = (h_cfg > AREA_W'(MAX_ROWS)) ? AREA_W'(MAX_ROWS) : h_cfg;

    assign cell_in_area = (AREA_W'(r_req.col) < w_eff) && (AREA_W'(r_req.row) < h_eff);

    // Rows never written since reset read as dead
    assign rd_row    = r_rd_vld ? r_rd_q : '0;
    assign row_en    = (AREA_W'(r_row) < h_eff);
    assign below_row = ((AREA_W'(r_row) + AREA_W'(1)) < h_eff) ? rd_row : '0;
    assign last_row  = (r_row == ROW_IDX_W'(MAX_ROWS - 1));

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && o_in_ready;

    // Shared row-update unit
    lag_row_unit u_row_unit (
        .i_above  (r_prev),
        .i_cur    (r_cur),
        .i_below  (below_row),
        .i_width  (w_eff),
        .i_row_en (row_en),
        .o_next   (new_row)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_req.mode == MODE_ADVANCE) ? S_ADV_LOAD1 : S_CELL_DONE;
                end
            end
            S_CELL_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ADV_LOAD1: begin
                n_state = S_ADV_ROW;
            end
            S_ADV_ROW: begin
                if (last_row) begin
                    n_state = S_ADV_END;
                end
            end
            S_ADV_END: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output decode
    always_comb begin
        o_in_ready  = 1'b0;
        mem_rd_addr = ROW_IDX_W'(r_req.row);
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_row;
        mem_wr_data = new_row;
        out_load    = 1'b0;
        out_next    = '{alive_out: 1'b0, generation_count: r_gen};
        gen_inc     = 1'b0;
        win_load    = 1'b0;
        win_shift   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                mem_rd_addr = (i_in_req.mode == MODE_ADVANCE) ? '0
                                                               : ROW_IDX_W'(i_in_req.row);
            end
            S_CELL_DONE: begin
                // Read-modify-write of one cell's row
                mem_wr_addr              = ROW_IDX_W'(r_req.row);
                mem_wr_data              = rd_row;
                mem_wr_data[r_req.col]   = r_req.alive_in;
                mem_wr_en                = (r_req.mode == MODE_WRITE) && cell_in_area;
                out_load                 = out_free;
                out_next.alive_out       = ((r_req.mode == MODE_READ) ||
                                            (r_req.mode == MODE_READ_ALT)) &&
                                           cell_in_area && rd_row[r_req.col];
            end
            S_ADV_LOAD1: begin
                mem_rd_addr = ROW_IDX_W'(1);
                win_load    = 1'b1;
            end
            S_ADV_ROW: begin
                // Write row r while row r+2 is fetched
                mem_rd_addr = r_row + ROW_IDX_W'(2);
                mem_wr_en   = 1'b1;
                win_shift   = 1'b1;
            end
            S_ADV_END: begin
                out_load                  = out_free;
                gen_inc                   = out_free;
                out_next.generation_count = r_gen + GEN_W'(1);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= CFG_W'(MAX_COLS);
            r_height    <= CFG_W'(MAX_ROWS);
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                    default:        r_width  <= r_width;
                endcase
            end
            if (gen_inc) begin
                r_gen <= r_gen + GEN_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, result and row window
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_req;
        end
        if (out_load) begin
            r_out <= out_next;
        end
        if (win_load) begin
            r_prev <= '0;
            r_cur  <= (h_eff != '0) ? rd_row : '0;
            r_row  <= '0;
        end else if (win_shift) begin
            r_prev <= r_cur;
            r_cur  <= below_row;
            r_row  <= r_row + ROW_IDX_W'(1);
        end
    end

    // Row memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rd_q <= r_mem[mem_rd_addr];
    end

    // Per-row valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_wr_en) begin
                r_row_vld[mem_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[mem_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: sv/lag_checker.sv
// ----------------------------------------------------------------------------
// lag_checker: port-level checks for the life grid stepper
// Watches the top level's handshakes and is bound to every instance of it.
// ----------------------------------------------------------------------------
module lag_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input lag_pkg::t_lag_in              i_in_req,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input lag_pkg::t_lag_out             o_out_req
);
    import lag_pkg::*;

    // A request keeps the block busy on the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted back to back");

    // An accepted advance keeps the block busy past the load state
    a_advance_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_req.mode == MODE_ADVANCE))
        |=> ##1 !o_in_ready)
        else $error("generation finished too early");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_req)))
        else $error("result dropped or changed while stalled");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind life_automaton_grid_step lag_checker u_lag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for life_automaton_grid_step
// Directed edge and corner patterns first, then random write/read/advance
// traffic over a series of grid sizes and idle mixes. A tracker class keeps
// its own copy of the grid and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
    import lag_pkg::*;

    // Shadow grid, generation counter and area registers; expected results in order
    class life_grid_tracker;
        bit [MAX_COLS-1:0] cells [MAX_ROWS];
        bit [GEN_W-1:0]    gens;
        bit [CFG_W-1:0]    width_reg;
        bit [CFG_W-1:0]    height_reg;
        t_lag_out          owed [$];
        int                mismatches;

        function new();
            foreach (cells[r]) cells[r] = '0;
            gens       = '0;
            width_reg  = 7'd64;
            height_reg = 7'd64;
            mismatches = 0;
        endfunction

        function int area_cols();
            return (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
        endfunction

        function int area_rows();
            return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
        endfunction

        function bit in_area(int c, int r);
            return (c < area_cols()) && (r < area_rows());
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_IDX_WIDTH) width_reg = val;
            else if (idx == CFG_IDX_HEIGHT) height_reg = val;
        endfunction

        // B3/S23 over the active area; everything outside ends up dead
        function void step_generation();
            bit [MAX_COLS-1:0] fresh [MAX_ROWS];
            int cols, rows, n;
            cols = area_cols();
            rows = area_rows();
            foreach (fresh[r]) fresh[r] = '0;
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
                                r + dr < rows && c + dc < cols)
                                n += cells[r + dr][c + dc];
                        end
                    end
                    if (n == 3) fresh[r][c] = 1'b1;
                    else if (n == 2) fresh[r][c] = cells[r][c];
                end
            end
            cells = fresh;
            gens++;
        endfunction

        function void note_request(t_lag_in req);
            t_lag_out want;
            want.alive_out = 1'b0;
            case (req.mode)
                MODE_WRITE: begin
                    if (in_area(int'(req.col), int'(req.row)))
                        cells[req.row][req.col] = req.alive_in;
                end
                MODE_ADVANCE: begin
                    step_generation();
                end
                default: begin
                    if (in_area(int'(req.col), int'(req.row)))
                        want.alive_out = cells[req.row][req.col];
                end
            endcase
            want.generation_count = gens;
            owed.push_back(want);
        endfunction

        function void check_result(t_lag_out got);
            t_lag_out want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: alive_out=%0b generation_count=%0d",
                             got.alive_out, got.generation_count);
                return;
            end
            want = owed.pop_front();
            if (got.alive_out !== want.alive_out ||
                got.generation_count !== want.generation_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: alive_out exp %0b got %0b, generation_count exp %0d got %0d",
                             want.alive_out, got.alive_out,
                             want.generation_count, got.generation_count);
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_lag_in              in_req    = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    t_lag_out             out_res;
    logic                 cfg_ready;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    life_grid_tracker books;

    life_automaton_grid_step dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side backpressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) books.check_result(out_res);
    end

    // One request; valid stays up after acceptance so the next one can follow back to back
    task automatic send_req(input t_lag_in req);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        books.note_request(req);
    endtask

    task automatic issue(input logic [1:0] mode, input int c, input int r, input bit alive);
        t_lag_in req;
        req.mode     = mode;
        req.col      = c[COL_W-1:0];
        req.row      = r[ROW_W-1:0];
        req.alive_in = alive;
        send_req(req);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        books.set_register(idx, val);
    endtask

    // Area change only once every outstanding request has returned
    task automatic set_area(input int w, input int h);
        in_valid <= 1'b0;
        while (books.owed.size() != 0) @(posedge clk);
        write_reg(CFG_IDX_WIDTH, w[CFG_W-1:0]);
        write_reg(CFG_IDX_HEIGHT, h[CFG_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // Mostly cells inside the area, some anywhere in the field range
    task automatic random_item();
        t_lag_in req;
        int cols, rows, pick;
        cols = books.area_cols();
        rows = books.area_rows();
        pick = $urandom_range(0, 99);
        if (pick < 38) req.mode = MODE_WRITE;
        else if (pick < 60) req.mode = MODE_READ;
        else if (pick < 82) req.mode = MODE_READ_ALT;
        else req.mode = MODE_ADVANCE;
        if (cols > 0 && rows > 0 && $urandom_range(0, 4) != 0) begin
            req.col = COL_W'($urandom_range(0, cols - 1));
            req.row = ROW_W'($urandom_range(0, rows - 1));
        end else begin
            req.col = COL_W'($urandom_range(0, 63));
            req.row = ROW_W'($urandom_range(0, 63));
        end
        req.alive_in = 1'($urandom_range(0, 1));
        send_req(req);
    endtask

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int w, h;
        books = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Corner cluster, single cell at far corner, blinker on the right edge
        issue(MODE_READ, 0, 0, 1'b0);
        issue(MODE_WRITE, 0, 0, 1'b1);
        issue(MODE_WRITE, 1, 0, 1'b1);
        issue(MODE_WRITE, 0, 1, 1'b1);
        issue(MODE_WRITE, 63, 63, 1'b1);
        issue(MODE_READ_ALT, 63, 63, 1'b0);
        issue(MODE_WRITE, 63, 10, 1'b1);
        issue(MODE_WRITE, 63, 11, 1'b1);
        issue(MODE_WRITE, 63, 12, 1'b1);
        issue(MODE_ADVANCE, 0, 0, 1'b0);
        issue(MODE_READ, 1, 1, 1'b0);
        issue(MODE_READ_ALT, 63, 63, 1'b0);
        issue(MODE_READ, 62, 11, 1'b0);
        // would be born if columns wrapped
        issue(MODE_READ, 0, 11, 1'b0);
        issue(MODE_WRITE, 0, 0, 1'b0);
        issue(MODE_READ, 0, 0, 1'b1);
        issue(MODE_ADVANCE, 63, 63, 1'b1);
        issue(MODE_READ, 62, 11, 1'b0);

        // Narrow area, height above limit; write and read outside
        set_area(3, 70);
        issue(MODE_WRITE, 5, 0, 1'b1);
        issue(MODE_READ, 5, 0, 1'b0);
        issue(MODE_READ, 1, 1, 1'b0);
        issue(MODE_READ_ALT, 2, 63, 1'b0);
        issue(MODE_ADVANCE, 0, 0, 1'b0);

        // Random phases: area and idle mix change together
        for (int p = 0; p < 12; p++) begin
            case (p)
                0:  begin w = 8;   h = 8;   end
                1:  begin w = 1;   h = 1;   end
                2:  begin w = 0;   h = 9;   end
                3:  begin w = 127; h = 127; end
                4:  begin w = 3;   h = 64;  end
                5:  begin w = 64;  h = 3;   end
                6:  begin w = 12;  h = 0;   end
                7:  begin w = 64;  h = 64;  end
                8:  begin w = 100; h = 10;  end
                default: begin
                    w = $urandom_range(2, 16);
                    h = $urandom_range(2, 16);
                end
            endcase
            set_area(w, h);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            repeat (128) random_item();
        end

        in_valid <= 1'b0;
        while (books.owed.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (books.mismatches == 0 && books.owed.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
